### hw/rtl/tsgc_pkg.sv
`default_nettype none

package tsgc_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned GEST_W    = 3;
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned DIM_REG_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_X     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_Y     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KEY   = 3'd3;

  // gesture codes
  localparam logic [GEST_W-1:0] GEST_TAP   = 3'd0;
  localparam logic [GEST_W-1:0] GEST_UP    = 3'd1;
  localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd2;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COORDS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_KEYS       = 3'd6;

  // reset values
  localparam logic [DIM_REG_W-1:0] RST_GRID_DIM  = 5'd3;
  localparam logic [VAL_W-1:0]     RST_RANGE     = 16'd4095;
  localparam logic [VAL_W-1:0]     RST_THRESHOLD = 16'd100;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] event_value;
  } in_t;

  typedef struct packed {
    logic              forward;
    logic              gesture_valid;
    logic [GEST_W-1:0] gesture;
    logic [CELL_W-1:0] cell_index;
  } out_t;

  // request to the shared slot divider
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] pos;
    logic [VAL_W-1:0] span;
  } slot_req_t;

endpackage

`default_nettype wire

### hw/rtl/tsgc_slot_div.sv
`default_nettype none

module tsgc_slot_div #(
  parameter int unsigned DIM_W = 5
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire tsgc_pkg::slot_req_t   req_i,
  input  wire  [DIM_W-1:0]           count_i,
  output logic                       done_o,
  output logic [DIM_W-1:0]           quot_o
);

  localparam int unsigned RW    = tsgc_pkg::VAL_W + DIM_W;
  localparam int unsigned CNT_W = $clog2(DIM_W + 1);

  logic [tsgc_pkg::VAL_W-1:0] pos_clamp;
  logic [tsgc_pkg::VAL_W-1:0] divisor;
  logic [RW-1:0]              prod;
  logic [RW-1:0]              rem_q, rem_d;
  logic [RW-1:0]              dsh_q;
  logic [DIM_W-1:0]           quot_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic                       ge;

  // position clamped to the range, range of zero divides by one
  assign pos_clamp = (req_i.pos > req_i.span) ? req_i.span : req_i.pos;
  assign divisor   = (req_i.span == '0) ? tsgc_pkg::VAL_W'(1) : req_i.span;
  assign prod      = RW'(pos_clamp) * RW'(count_i);

  // restoring step, one quotient bit a cycle
  assign ge    = (rem_q >= dsh_q);
  assign rem_d = ge ? (rem_q - dsh_q) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= prod;
      dsh_q  <= RW'(divisor) << (DIM_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dsh_q  <= dsh_q >> 1;
      quot_q <= DIM_W'({quot_q, ge});
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### hw/rtl/touch_swipe_grid_classifier_top.sv
// Touchpad gesture classifier. Each accepted input transaction yields exactly one
// output transaction carrying the forward flag and, on a touch release that ends an
// active session, the gesture and the grid cell of the start point. Every event but
// such a release is answered in the cycle after it is accepted. A release with an
// active session runs two divisions (row, then column) on one shared restoring
// divider that produces one quotient bit per cycle; no input is taken until the
// result is in the output register. Results sit in an output register; a new
// event is accepted only once the previous result is taken, at the earliest in the
// same cycle. Configuration writes go straight to the registers and should only be
// made while the block is idle.
`default_nettype none

module touch_swipe_grid_classifier_top #(
  parameter int unsigned GRID_DIM_MAX = 16,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire  [tsgc_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire  [tsgc_pkg::VAL_W-1:0]                cfg_data_i,
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire tsgc_pkg::in_t                        in_data_i,
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output tsgc_pkg::out_t                            out_data_o
);

  localparam int unsigned DIM_W  = $clog2(GRID_DIM_MAX + 1);
  localparam int unsigned PROD_W = 2 * DIM_W + 1;
  localparam logic [COORD_BITS-1:0] SENT = {COORD_BITS{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REQ_Y  = 6'b000010,
    S_WAIT_Y = 6'b000100,
    S_REQ_X  = 6'b001000,
    S_WAIT_X = 6'b010000,
    S_CELL   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [tsgc_pkg::DIM_REG_W-1:0] grid_rows_q, grid_cols_q;
  logic [tsgc_pkg::VAL_W-1:0]     range_x_q, range_y_q, thresh_q;
  logic                           stop_coords_q, stop_keys_q;

  // tracking state
  logic [COORD_BITS-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic                  session_q, session_d, touch_q, touch_d;

  logic [tsgc_pkg::GEST_W-1:0] gest_q, gest_d;
  logic [DIM_W-1:0]            qy_q, qy_d, qx_q, qx_d;

  logic                out_valid_q, out_valid_d;
  tsgc_pkg::out_t      out_q, out_d;

  logic                in_acc, out_free;
  logic [COORD_BITS-1:0] coord;
  logic                neg_x, neg_y;
  logic [COORD_BITS-1:0] adx, ady;
  logic [tsgc_pkg::GEST_W-1:0] gest_now;
  logic [DIM_W-1:0]    rows_sat, cols_sat, slot, cnt_sel;
  logic [PROD_W-1:0]   cell_full;

  tsgc_pkg::slot_req_t slot_req;
  logic                slot_done;
  logic [DIM_W-1:0]    slot_quot;

  // grid dimensions saturated to 1..GRID_DIM_MAX
  always_comb begin
    if (grid_rows_q == '0) begin
      rows_sat = DIM_W'(1);
    end else if (32'(grid_rows_q) > 32'(GRID_DIM_MAX)) begin
      rows_sat = DIM_W'(GRID_DIM_MAX);
    end else begin
      rows_sat = DIM_W'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      cols_sat = DIM_W'(1);
    end else if (32'(grid_cols_q) > 32'(GRID_DIM_MAX)) begin
      cols_sat = DIM_W'(GRID_DIM_MAX);
    end else begin
      cols_sat = DIM_W'(grid_cols_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q   <= tsgc_pkg::RST_GRID_DIM;
      grid_cols_q   <= tsgc_pkg::RST_GRID_DIM;
      range_x_q     <= tsgc_pkg::RST_RANGE;
      range_y_q     <= tsgc_pkg::RST_RANGE;
      thresh_q      <= tsgc_pkg::RST_THRESHOLD;
      stop_coords_q <= 1'b0;
      stop_keys_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsgc_pkg::REG_GRID_ROWS:       grid_rows_q   <= cfg_data_i[tsgc_pkg::DIM_REG_W-1:0];
        tsgc_pkg::REG_GRID_COLUMNS:    grid_cols_q   <= cfg_data_i[tsgc_pkg::DIM_REG_W-1:0];
        tsgc_pkg::REG_RANGE_X:         range_x_q     <= cfg_data_i;
        tsgc_pkg::REG_RANGE_Y:         range_y_q     <= cfg_data_i;
        tsgc_pkg::REG_SWIPE_THRESHOLD: thresh_q      <= cfg_data_i;
        tsgc_pkg::REG_STOP_COORDS:     stop_coords_q <= cfg_data_i[0];
        tsgc_pkg::REG_STOP_KEYS:       stop_keys_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign coord      = COORD_BITS'(in_data_i.event_value);

  // gesture from the deltas, ties go to the x axis
  always_comb begin
    neg_x = last_x_q < start_x_q;
    neg_y = last_y_q < start_y_q;
    adx   = neg_x ? (start_x_q - last_x_q) : (last_x_q - start_x_q);
    ady   = neg_y ? (start_y_q - last_y_q) : (last_y_q - start_y_q);
    if ((tsgc_pkg::VAL_W'(adx) < thresh_q) && (tsgc_pkg::VAL_W'(ady) < thresh_q)) begin
      gest_now = tsgc_pkg::GEST_TAP;
    end else if (ady > adx) begin
      gest_now = neg_y ? tsgc_pkg::GEST_UP : tsgc_pkg::GEST_DOWN;
    end else begin
      gest_now = neg_x ? tsgc_pkg::GEST_LEFT : tsgc_pkg::GEST_RIGHT;
    end
  end

  // shared divider request, row count held while the row quotient is clamped
  always_comb begin
    slot_req.start = (state_q == S_REQ_Y) || (state_q == S_REQ_X);
    if ((state_q == S_REQ_Y) || (state_q == S_WAIT_Y)) begin
      slot_req.pos  = tsgc_pkg::VAL_W'(start_y_q);
      slot_req.span = range_y_q;
      cnt_sel       = rows_sat;
    end else begin
      slot_req.pos  = tsgc_pkg::VAL_W'(start_x_q);
      slot_req.span = range_x_q;
      cnt_sel       = cols_sat;
    end
  end

  tsgc_slot_div #(
    .DIM_W (DIM_W)
  ) u_slot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (slot_req),
    .count_i (cnt_sel),
    .done_o  (slot_done),
    .quot_o  (slot_quot)
  );

  // quotient clamped to count - 1
  assign slot = (slot_quot >= cnt_sel) ? (cnt_sel - DIM_W'(1)) : slot_quot;

  assign cell_full = PROD_W'(qy_q) * PROD_W'(cols_sat) + PROD_W'(qx_q);

  always_comb begin
    state_d     = state_q;
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    session_d   = session_q;
    touch_d     = touch_q;
    gest_d      = gest_q;
    qy_d        = qy_q;
    qx_d        = qx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.forward = 1'b1;
          case (in_data_i.command)
            tsgc_pkg::CMD_X, tsgc_pkg::CMD_Y: begin
              if (touch_q) begin
                if (in_data_i.command == tsgc_pkg::CMD_X) begin
                  if (start_x_q == SENT) start_x_d = coord;
                  last_x_d = coord;
                end else begin
                  if (start_y_q == SENT) start_y_d = coord;
                  last_y_d = coord;
                end
                if ((start_x_d != SENT) && (start_y_d != SENT)) session_d = 1'b1;
              end
              out_d.forward = !stop_coords_q;
            end
            tsgc_pkg::CMD_TOUCH: begin
              out_d.forward = !stop_keys_q;
              touch_d       = (in_data_i.event_value != '0);
              session_d     = 1'b0;
              if (in_data_i.event_value != '0) begin
                start_x_d = SENT;
                start_y_d = SENT;
                last_x_d  = SENT;
                last_y_d  = SENT;
              end else if (session_q) begin
                // result held back until the cell is known
                out_valid_d = 1'b0;
                out_d       = out_q;
                gest_d      = gest_now;
                state_d     = S_REQ_Y;
              end
            end
            tsgc_pkg::CMD_KEY: begin
              out_d.forward = !stop_keys_q;
            end
            default: ;
          endcase
        end
      end
      S_REQ_Y: state_d = S_WAIT_Y;
      S_WAIT_Y: begin
        if (slot_done) begin
          qy_d    = slot;
          state_d = S_REQ_X;
        end
      end
      S_REQ_X: state_d = S_WAIT_X;
      S_WAIT_X: begin
        if (slot_done) begin
          qx_d    = slot;
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.forward       = !stop_keys_q;
          out_d.gesture_valid = 1'b1;
          out_d.gesture       = gest_q;
          out_d.cell_index    = tsgc_pkg::CELL_W'(cell_full);
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_x_q   <= SENT;
      start_y_q   <= SENT;
      last_x_q    <= SENT;
      last_y_q    <= SENT;
      session_q   <= 1'b0;
      touch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      session_q   <= session_d;
      touch_q     <= touch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gest_q <= gest_d;
    qy_q   <= qy_d;
    qx_q   <= qx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divider only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_done |-> (state_q == S_WAIT_Y || state_q == S_WAIT_X))
    else $error("slot divider finished outside a wait state");

  // no gesture means empty gesture fields
  a_no_gesture_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.gesture_valid) |->
      (out_data_o.gesture == tsgc_pkg::GEST_TAP && out_data_o.cell_index == '0))
    else $error("gesture fields set without a gesture");

  // the row slot lies inside the grid
  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REQ_X) |-> (qy_q < rows_sat))
    else $error("row slot outside the grid");

  // finishing the cell always presents a gesture result
  a_cell_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL && out_free) |=> (out_valid_o && out_data_o.gesture_valid))
    else $error("cell step did not deliver a gesture");

endmodule

`default_nettype wire
